@@ sv/motor_status_packet_receiver_defines.svh @@
// Assertion macros shared by the motor status packet receiver RTL
`ifndef MOTOR_STATUS_PACKET_RECEIVER_DEFINES_SVH
`define MOTOR_STATUS_PACKET_RECEIVER_DEFINES_SVH

// Concurrent check on a named clock, switched off while reset is high
`define MSP_ASSERT_ON(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check on the block clock and reset
`define MSP_ASSERT(label, prop, msg) `MSP_ASSERT_ON(label, clock, reset, prop, msg)

`endif

@@ sv/msp_rx_pkg.sv @@
// Types and constants of the motor status packet receiver
package msp_rx_pkg;

   localparam int COUNT_W     = 8;
   localparam int STORE_DEPTH = 14;
   localparam int STORE_IDX_W = 4;

   localparam logic [7:0] BROADCAST_ID = 8'hFE;
   localparam logic [7:0] MONITOR_KIND = 8'd216;
   localparam logic [7:0] MONITOR_LEN  = 8'd14;

   localparam logic [7:0] HOST_ID_RESET   = 8'd184;
   localparam logic [7:0] DRIVER_ID_RESET = 8'd183;
   localparam logic [7:0] MOTOR_ID_RESET  = 8'd1;

   // register indexes on the csr port
   localparam logic [1:0] REG_HOST_ID   = 2'd0;
   localparam logic [1:0] REG_DRIVER_ID = 2'd1;
   localparam logic [1:0] REG_MOTOR_ID  = 2'd2;

   typedef enum logic [2:0] {
      STEP_HOST   = 3'd0,
      STEP_DRIVER = 3'd1,
      STEP_MOTOR  = 3'd2,
      STEP_KIND   = 3'd3,
      STEP_LEN    = 3'd4,
      STEP_DATA   = 3'd5,
      STEP_SUM    = 3'd6
   } parse_step_type;

   typedef struct packed {
      logic [7:0] host_id;
      logic [7:0] driver_id;
      logic [7:0] motor_id;
   } msp_rx_cfg_type;

   typedef struct packed {
      logic               checksum_ok;
      logic [7:0]         packet_kind;
      logic               monitor_valid;
      logic [15:0]        right_speed;
      logic [7:0]         right_status;
      logic signed [31:0] right_pos;
      logic [15:0]        left_speed;
      logic [7:0]         left_status;
      logic signed [31:0] left_pos;
   } msp_rx_result_type;

endpackage

@@ sv/msp_rx_if.sv @@
// Byte and result channel interfaces of the motor status packet receiver
interface msp_rx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface msp_rx_rsp_if;
   logic               valid;
   logic               ready;
   logic               checksum_ok;
   logic [7:0]         packet_kind;
   logic               monitor_valid;
   logic [15:0]        right_speed;
   logic [7:0]         right_status;
   logic signed [31:0] right_pos;
   logic [15:0]        left_speed;
   logic [7:0]         left_status;
   logic signed [31:0] left_pos;

   modport source (output valid, output checksum_ok, output packet_kind,
                   output monitor_valid, output right_speed, output right_status,
                   output right_pos, output left_speed, output left_status,
                   output left_pos, input ready);
   modport sink   (input valid, input checksum_ok, input packet_kind,
                   input monitor_valid, input right_speed, input right_status,
                   input right_pos, input left_speed, input left_status,
                   input left_pos, output ready);
endinterface

@@ sv/msp_rx_parser.sv @@
// Frame parser: step state, running checksum, payload bytes and result decode
module msp_rx_parser import msp_rx_pkg::*; #(
   parameter int DATA_LIMIT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [7:0]        rx_byte,
   input  msp_rx_cfg_type    cfg,
   output logic              emit,
   output msp_rx_result_type result
);

   localparam logic [COUNT_W-1:0] LimitVal = COUNT_W'(DATA_LIMIT);

   parse_step_type     step_ff, step_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         kind_ff, kind_in;
   logic [7:0]         len_ff, len_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         store_ff [STORE_DEPTH];

   logic [7:0]         sum_add;
   logic [COUNT_W-1:0] count_inc;
   logic               host_hit, driver_hit, motor_hit;
   logic               sum_ok, monitor;

   assign sum_add    = sum_ff + rx_byte;
   assign count_inc  = count_ff + COUNT_W'(1);
   assign host_hit   = (rx_byte == cfg.host_id);
   assign driver_hit = host_hit || (rx_byte == cfg.driver_id);
   assign motor_hit  = (rx_byte == cfg.motor_id) || (rx_byte == BROADCAST_ID);

   // next step
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         STEP_HOST:   step_in = host_hit ? STEP_DRIVER : STEP_HOST;
         STEP_DRIVER: step_in = driver_hit ? STEP_MOTOR : STEP_HOST;
         STEP_MOTOR:  step_in = motor_hit ? STEP_KIND : STEP_HOST;
         STEP_KIND:   step_in = STEP_LEN;
         STEP_LEN:    step_in = STEP_DATA;
         STEP_DATA: begin
            priority if (count_inc >= LimitVal) begin
               step_in = STEP_HOST;
            end else if (count_inc >= len_ff) begin
               step_in = STEP_SUM;
            end else begin
               step_in = STEP_DATA;
            end
         end
         STEP_SUM:    step_in = STEP_HOST;
         default:     step_in = STEP_HOST;
      endcase
   end

   // datapath updates per step
   always_comb begin
      sum_in   = sum_ff;
      kind_in  = kind_ff;
      len_in   = len_ff;
      count_in = count_ff;
      unique case (step_ff)
         STEP_HOST: begin
            if (host_hit) sum_in = rx_byte;
         end
         STEP_DRIVER: begin
            if (driver_hit) sum_in = sum_add;
         end
         STEP_MOTOR: begin
            if (motor_hit) sum_in = sum_add;
         end
         STEP_KIND: begin
            sum_in  = sum_add;
            kind_in = rx_byte;
         end
         STEP_LEN: begin
            sum_in   = sum_add;
            len_in   = rx_byte;
            count_in = '0;
         end
         STEP_DATA: begin
            sum_in   = sum_add;
            count_in = count_inc;
         end
         STEP_SUM:  sum_in = sum_add;
         default:   sum_in = sum_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_HOST;
         sum_ff   <= '0;
         kind_ff  <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         step_ff  <= step_in;
         sum_ff   <= sum_in;
         kind_ff  <= kind_in;
         len_ff   <= len_in;
         count_ff <= count_in;
      end
   end

   // only the first bytes of the payload are kept
   always_ff @(posedge clock) begin
      if (step_en && step_ff == STEP_DATA && count_ff < COUNT_W'(STORE_DEPTH)) begin
         store_ff[count_ff[STORE_IDX_W-1:0]] <= rx_byte;
      end
   end

   assign emit    = (step_ff == STEP_SUM);
   assign sum_ok  = (sum_add == 8'd0);
   assign monitor = sum_ok && kind_ff == MONITOR_KIND && len_ff == MONITOR_LEN;

   always_comb begin
      result               = '0;
      result.checksum_ok   = sum_ok;
      result.packet_kind   = kind_ff;
      result.monitor_valid = monitor;
      if (monitor) begin
         result.right_speed  = {store_ff[1], store_ff[0]};
         result.right_status = store_ff[2];
         result.right_pos    = $signed({store_ff[6], store_ff[5], store_ff[4], store_ff[3]});
         result.left_speed   = {store_ff[8], store_ff[7]};
         result.left_status  = store_ff[9];
         result.left_pos     = $signed({store_ff[13], store_ff[12], store_ff[11],
                                        store_ff[10]});
      end
   end

endmodule

@@ sv/motor_status_packet_receiver.sv @@
// Top level of the motor status packet receiver: byte register, parser, result register, csr
// Takes one received byte per clock and parses host id, driver id, motor id, packet id,
// length, data and checksum bytes; on the checksum byte it delivers one result word with the
// checksum status, the packet id and, for a good monitor packet (id 216, length 14), both
// motors' speed, status and position. A byte is registered on accept, then parsed; a parsed
// checksum byte loads its result into the result register, which drives rsp. The block
// sustains one byte per cycle; it only holds req.ready low while a parsed checksum byte waits
// for the result register, which frees once rsp.ready takes the previous result word. Frames
// whose data count reaches DATA_LIMIT are dropped without a result. The user must write host_id
// (0x0), driver_id (0x4) and motor_id (0x8) over the APB port only while no frame is in flight; not enforced.
`include "motor_status_packet_receiver_defines.svh"

module motor_status_packet_receiver import msp_rx_pkg::*; #(
   parameter int DATA_LIMIT = 64
) (
   input  logic         clock,
   input  logic         reset,
   msp_rx_req_if.sink   req,
   msp_rx_rsp_if.source rsp,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [3:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   msp_rx_cfg_type    cfg_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   msp_rx_result_type rsp_data_ff;
   msp_rx_result_type result;
   logic              emit;
   logic              out_free;
   logic              s1_fire;
   logic              req_take;
   logic [1:0]        reg_idx;
   logic [7:0]        rd_byte;

   // ---- csr port ----
   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.host_id   <= HOST_ID_RESET;
         cfg_ff.driver_id <= DRIVER_ID_RESET;
         cfg_ff.motor_id  <= MOTOR_ID_RESET;
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_HOST_ID:   cfg_ff.host_id   <= pwdata[7:0];
            REG_DRIVER_ID: cfg_ff.driver_id <= pwdata[7:0];
            REG_MOTOR_ID:  cfg_ff.motor_id  <= pwdata[7:0];
            default:       cfg_ff.motor_id  <= cfg_ff.motor_id;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HOST_ID:   rd_byte = cfg_ff.host_id;
         REG_DRIVER_ID: rd_byte = cfg_ff.driver_id;
         REG_MOTOR_ID:  rd_byte = cfg_ff.motor_id;
         default:       rd_byte = 8'd0;
      endcase
   end

   assign prdata = {24'd0, rd_byte};

   // ---- byte register and result register ----
   assign out_free  = !rsp_valid_ff || rsp.ready;
   // a byte that yields no result never waits on the result side
   assign s1_fire   = s1_valid_ff && (!emit || out_free);
   assign req.ready = !s1_valid_ff || s1_fire;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) s1_byte_ff <= req.rx_byte;
      if (s1_fire && emit) rsp_data_ff <= result;
   end

   msp_rx_parser #(
      .DATA_LIMIT (DATA_LIMIT)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_fire),
      .rx_byte (s1_byte_ff),
      .cfg     (cfg_ff),
      .emit    (emit),
      .result  (result)
   );

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.checksum_ok   = rsp_data_ff.checksum_ok;
   assign rsp.packet_kind   = rsp_data_ff.packet_kind;
   assign rsp.monitor_valid = rsp_data_ff.monitor_valid;
   assign rsp.right_speed   = rsp_data_ff.right_speed;
   assign rsp.right_status  = rsp_data_ff.right_status;
   assign rsp.right_pos     = rsp_data_ff.right_pos;
   assign rsp.left_speed    = rsp_data_ff.left_speed;
   assign rsp.left_status   = rsp_data_ff.left_status;
   assign rsp.left_pos      = rsp_data_ff.left_pos;

   // ---- checks ----
   `MSP_ASSERT(a_monitor_needs_sum,
      rsp_valid_ff |-> (!rsp_data_ff.monitor_valid || rsp_data_ff.checksum_ok),
      "monitor word without good checksum")
   `MSP_ASSERT(a_plain_word_zero,
      (rsp_valid_ff && !rsp_data_ff.monitor_valid) |->
         (rsp_data_ff.right_pos == 0 && rsp_data_ff.left_pos == 0 &&
          rsp_data_ff.right_speed == 16'd0 && rsp_data_ff.left_speed == 16'd0),
      "motor fields set on non monitor word")
   `MSP_ASSERT(a_byte_held,
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_byte_ff)),
      "stalled byte lost")
   `MSP_ASSERT(a_result_loaded, (s1_fire && emit) |=> rsp_valid_ff,
      "checksum byte gave no result word")

endmodule

@@ verif/tb_motor_status_packet_receiver.sv @@
// Self-checking testbench for the motor status packet receiver: byte stream in, status words out
`timescale 1ns / 100ps

module tb_motor_status_packet_receiver;
   import msp_rx_pkg::*;

   localparam int DATA_LIMIT    = 64;
   localparam int RANDOM_BUDGET = 200;   // bytes of random traffic per id setting
   localparam int SETTLE_CYCLES = 8;     // headroom after the bytes and status words drain
   localparam int CYCLE_LIMIT   = 500000;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   msp_rx_req_if req_if ();
   msp_rx_rsp_if rsp_if ();

   motor_status_packet_receiver #(.DATA_LIMIT(DATA_LIMIT)) uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // parser shadow
   msp_rx_cfg_type    ids;
   parse_step_type    rx_step;
   logic [7:0]        frame_sum;
   logic [7:0]        frame_kind;
   logic [7:0]        frame_len;
   int                data_seen;
   logic [7:0]        payload [STORE_DEPTH];
   msp_rx_result_type status_words [$];

   logic [7:0] rx_pending [$];
   int         bytes_sent;
   int         bytes_taken;
   int         send_gap;
   int         stall_left;
   bit         idle_on;
   int         errors;
   int         words_seen;
   int         monitor_seen;
   int         bad_sum_seen;
   int         settings_run;
   int         cycle_count;

   function automatic void parse_rx_byte(input logic [7:0] b);
      msp_rx_result_type r;
      case (rx_step)
         STEP_HOST: begin
            if (b == ids.host_id) begin
               frame_sum = b;
               rx_step   = STEP_DRIVER;
            end
         end
         STEP_DRIVER: begin
            if (b == ids.host_id || b == ids.driver_id) begin
               frame_sum = frame_sum + b;
               rx_step   = STEP_MOTOR;
            end else begin
               rx_step = STEP_HOST;
            end
         end
         STEP_MOTOR: begin
            if (b == ids.motor_id || b == BROADCAST_ID) begin
               frame_sum = frame_sum + b;
               rx_step   = STEP_KIND;
            end else begin
               rx_step = STEP_HOST;
            end
         end
         STEP_KIND: begin
            frame_sum  = frame_sum + b;
            frame_kind = b;
            rx_step    = STEP_LEN;
         end
         STEP_LEN: begin
            frame_sum = frame_sum + b;
            frame_len = b;
            data_seen = 0;
            rx_step   = STEP_DATA;
         end
         STEP_DATA: begin
            frame_sum = frame_sum + b;
            if (data_seen < STORE_DEPTH) payload[data_seen] = b;
            data_seen++;
            if (data_seen >= DATA_LIMIT) rx_step = STEP_HOST;      // dropped, no word
            else if (data_seen >= frame_len) rx_step = STEP_SUM;
         end
         STEP_SUM: begin
            frame_sum       = frame_sum + b;
            rx_step         = STEP_HOST;
            r               = '0;
            r.checksum_ok   = (frame_sum == 8'h00);
            r.packet_kind   = frame_kind;
            r.monitor_valid = r.checksum_ok && frame_kind == MONITOR_KIND
                              && frame_len == MONITOR_LEN;
            if (r.monitor_valid) begin
               r.right_speed  = {payload[1], payload[0]};
               r.right_status = payload[2];
               r.right_pos    = {payload[6], payload[5], payload[4], payload[3]};
               r.left_speed   = {payload[8], payload[7]};
               r.left_status  = payload[9];
               r.left_pos     = {payload[13], payload[12], payload[11], payload[10]};
            end
            status_words.push_back(r);
         end
         default: rx_step = STEP_HOST;
      endcase
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   function automatic void check_status_word();
      msp_rx_result_type want;
      if (status_words.size() == 0) begin
         errors++;
         $display("%0t: unexpected status word: expected none, actual kind %0d ok %b",
                  $time, rsp_if.packet_kind, rsp_if.checksum_ok);
         return;
      end
      want = status_words.pop_front();
      words_seen++;
      if (want.monitor_valid) monitor_seen++;
      if (!want.checksum_ok) bad_sum_seen++;
      check_field("checksum_ok",   want.checksum_ok,   rsp_if.checksum_ok);
      check_field("packet_kind",   want.packet_kind,   rsp_if.packet_kind);
      check_field("monitor_valid", want.monitor_valid, rsp_if.monitor_valid);
      check_field("right_speed",   want.right_speed,   rsp_if.right_speed);
      check_field("right_status",  want.right_status,  rsp_if.right_status);
      check_field("right_pos",     want.right_pos,     rsp_if.right_pos);
      check_field("left_speed",    want.left_speed,    rsp_if.left_speed);
      check_field("left_status",   want.left_status,   rsp_if.left_status);
      check_field("left_pos",      want.left_pos,      rsp_if.left_pos);
   endfunction

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            parse_rx_byte(req_if.rx_byte);
            bytes_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (rx_pending.size() > 0) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_pending.pop_front();
               send_gap = pick_gap();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // status word monitor with random backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_status_word();
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d status words still due",
                  cycle_count, status_words.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void push_byte(input logic [7:0] b);
      rx_pending.push_back(b);
      bytes_sent++;
   endfunction

   // one frame with random id choices; keep > 0 truncates it, edge_data loads extreme values
   task automatic add_frame(input logic [7:0] kind, input logic [7:0] len, input bit corrupt,
                            input bit edge_data, input int keep);
      logic [7:0] words [$];
      logic [7:0] sum;
      logic [7:0] cks;
      int         count;
      int         k;
      words.push_back(ids.host_id);
      words.push_back($urandom_range(0, 1) ? ids.host_id : ids.driver_id);
      words.push_back($urandom_range(0, 1) ? ids.motor_id : BROADCAST_ID);
      words.push_back(kind);
      words.push_back(len);
      count = (len == 0) ? 1 : len;
      if (count > DATA_LIMIT) count = DATA_LIMIT;
      for (k = 0; k < count; k++) begin
         if (edge_data)
            words.push_back(k == 6 ? 8'h80 : k == 13 ? 8'h7F : k >= 7 ? 8'hFF : 8'h00);
         else
            words.push_back(8'($urandom));
      end
      // a frame that reaches the data limit never gets a checksum byte
      if (count < DATA_LIMIT) begin
         sum = 8'h00;
         for (k = 0; k < words.size(); k++) sum = sum + words[k];
         cks = 8'h00 - sum;
         if (corrupt) cks = cks + 8'($urandom_range(1, 255));
         words.push_back(cks);
      end
      for (k = 0; k < words.size() && (keep == 0 || k < keep); k++) push_byte(words[k]);
   endtask

   task automatic random_traffic(input int budget);
      int start;
      int pick;
      bit bad;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         bad  = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 99) < 3) idle_on = !idle_on;
         if (pick < 40)
            add_frame(MONITOR_KIND, MONITOR_LEN, bad, 1'b0, 0);
         else if (pick < 58)
            add_frame(8'($urandom), 8'($urandom_range(1, 20)), bad, 1'b0, 0);
         else if (pick < 64)
            add_frame(8'($urandom), MONITOR_LEN, bad, 1'b0, 0);
         else if (pick < 68)
            add_frame(MONITOR_KIND, 8'($urandom_range(0, 20)), bad, 1'b0, 0);
         else if (pick < 72)
            add_frame(8'($urandom), 8'($urandom_range(DATA_LIMIT - 3, 255)), bad, 1'b0, 0);
         else if (pick < 78)
            add_frame(8'($urandom), 8'($urandom), 1'b0, 1'b0, $urandom_range(1, 6));
         else if (pick < 84) begin
            // id prefix with a random byte where an id is due
            push_byte(ids.host_id);
            if ($urandom_range(0, 1)) push_byte(ids.driver_id);
            push_byte(8'($urandom));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
         end else
            add_frame(8'($urandom), 8'h00, bad, 1'b0, 0);
      end
   endtask

   task automatic wait_drained();
      while (bytes_taken != bytes_sent || status_words.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // leave the parser waiting for a host id before any register write
   task automatic settle_idle();
      wait_drained();
      while (rx_step != STEP_HOST) begin
         push_byte(8'($urandom));
         wait_drained();
      end
   endtask

   // write one register, then read it back
   task automatic csr_write(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== {24'd0, value} || pready !== 1'b1) begin
         errors++;
         $display("%0t: register %0d readback mismatch: expected %h, actual %h",
                  $time, index, {24'd0, value}, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      case (index)
         REG_HOST_ID:   ids.host_id   = value;
         REG_DRIVER_ID: ids.driver_id = value;
         REG_MOTOR_ID:  ids.motor_id  = value;
         default: ;
      endcase
   endtask

   task automatic set_ids(input logic [7:0] host, input logic [7:0] driver,
                          input logic [7:0] motor);
      csr_write(REG_HOST_ID, host);
      csr_write(REG_DRIVER_ID, driver);
      csr_write(REG_MOTOR_ID, motor);
      @(negedge clock);
   endtask

   initial begin
      int setting;
      clock          = 1'b0;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      ids            = '{host_id: HOST_ID_RESET, driver_id: DRIVER_ID_RESET,
                         motor_id: MOTOR_ID_RESET};
      rx_step        = STEP_HOST;
      frame_sum      = '0;
      frame_kind     = '0;
      frame_len      = '0;
      data_seen      = 0;
      idle_on        = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, on the reset ids
      add_frame(MONITOR_KIND, MONITOR_LEN, 1'b0, 1'b1, 0);
      push_byte(ids.host_id);
      push_byte(8'h00);                 // bad driver byte
      push_byte(ids.host_id);
      push_byte(ids.host_id);
      push_byte(ids.host_id);           // bad motor byte, consumed, not a new frame start
      add_frame(8'h00, 8'h00, 1'b1, 1'b0, 0);
      random_traffic(RANDOM_BUDGET);
      settle_idle();
      settings_run = 1;

      for (setting = 1; setting <= 6; setting++) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case (setting)
            1: set_ids(8'h00, 8'hFF, 8'h00);
            2: set_ids(8'hFF, 8'h00, 8'hFF);
            3: set_ids(BROADCAST_ID, BROADCAST_ID, BROADCAST_ID);
            4: set_ids(8'($urandom), 8'($urandom), 8'($urandom));
            5: set_ids(8'($urandom), 8'($urandom), 8'($urandom));
            default: set_ids(HOST_ID_RESET, DRIVER_ID_RESET, MOTOR_ID_RESET);
         endcase
         random_traffic(RANDOM_BUDGET);
         settle_idle();
         settings_run++;
      end

      $display("Sent %0d bytes under %0d id settings, including broken and over-long frames",
               bytes_taken, settings_run);
      $display("Checked %0d status words: %0d monitor decodes, %0d bad checksums",
               words_seen, monitor_seen, bad_sum_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
